// ===== hw/rtl/knntk_pkg.sv =====
// shared types and constants for the k-nearest-neighbor distance list
`default_nettype none

package knntk_pkg;

  // configuration register map
  localparam int unsigned KCFG_W     = 5;
  localparam logic [KCFG_W-1:0] K_RESET = 5'd5;
  localparam int unsigned REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_K_IN_USE = 1'b0;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // report format
  localparam int unsigned RANK_W = 4;
  localparam int unsigned LABEL_W = 8;

  // flags travelling with an item through the distance pipeline
  typedef struct packed {
    logic vld;
    logic last_attr;
    logic last_ref;
  } item_flags_t;

  // events from the distance pipeline to the list
  typedef struct packed {
    logic ins;   // candidate distance ready for insertion
    logic done;  // last reference of the query has passed
  } dist_ev_t;

  // per-cycle command to every cell of the list
  typedef struct packed {
    logic ins;   // compare-and-shift insertion
    logic emit;  // shift toward rank 0 for reporting
    logic clr;   // drop all entries
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/knn_top_k_distance_list.sv =====
// top level of the k-nearest-neighbor squared distance list
`default_nettype none

// Streams one query/reference attribute pair per cycle, while in_ready_o is
// high, through a pipeline (difference, square, saturating sum, list
// insertion). The list is a row of K_MAX cells that inserts a finished
// reference distance by compare-and-shift. An item with last_ref set closes
// the query: from its acceptance in_ready_o stays low until all k results
// have been moved into the output register, one per cycle that out_ready_i
// allows. Slot state is held in flip-flops with reset-cleared valid bits, so
// no clearing pass is needed after reset. k_in_use sits at byte address 0 of
// the APB port.

module knn_top_k_distance_list import knntk_pkg::*; #(
  parameter int unsigned K_MAX      = 16,
  parameter int unsigned ATTR_WIDTH = 16,
  parameter int unsigned DIST_WIDTH = 48
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // apb configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  // input channel
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [ATTR_WIDTH-1:0] query_attr_i,
  input  wire logic [ATTR_WIDTH-1:0] ref_attr_i,
  input  wire logic [LABEL_W-1:0]    ref_label_i,
  input  wire logic                  last_attr_i,
  input  wire logic                  last_ref_i,
  // output channel
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [RANK_W-1:0]     rank_o,
  output logic      [DIST_WIDTH-1:0] neighbour_dist_o,
  output logic      [LABEL_W-1:0]    neighbour_label_o,
  output logic                       slot_filled_o,
  output logic                       last_of_run_o
);

  localparam int unsigned KW = $clog2(K_MAX + 1);
  localparam int unsigned CW = (KW > KCFG_W) ? KW : KCFG_W;

  // configuration register
  logic [KCFG_W-1:0] k_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_K_IN_USE);
  assign prdata = (paddr[APB_ADDR_W-1] == REG_K_IN_USE) ? APB_DATA_W'(k_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= K_RESET;
    end else if (cfg_wr) begin
      k_q <= pwdata[KCFG_W-1:0];
    end
  end

  // effective k, clamped to 1..K_MAX
  logic [CW-1:0] k_ext, k_act;
  assign k_ext = CW'(k_q);
  always_comb begin
    if (k_ext == '0) begin
      k_act = CW'(1);
    end else if (k_ext > CW'(K_MAX)) begin
      k_act = CW'(K_MAX);
    end else begin
      k_act = k_ext;
    end
  end

  // input acceptance
  logic in_fire;
  logic busy_q;
  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;

  // distance pipeline
  dist_ev_t              ev;
  logic [DIST_WIDTH-1:0] ins_dist;
  logic [LABEL_W-1:0]    ins_label;

  knntk_dist #(
    .ATTR_WIDTH (ATTR_WIDTH),
    .DIST_WIDTH (DIST_WIDTH)
  ) u_dist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (in_fire),
    .query_attr_i (query_attr_i),
    .ref_attr_i   (ref_attr_i),
    .ref_label_i  (ref_label_i),
    .last_attr_i  (last_attr_i),
    .last_ref_i   (last_ref_i),
    .ev_o         (ev),
    .ins_dist_o   (ins_dist),
    .ins_label_o  (ins_label)
  );

  // report sequencing
  logic          emitting_q;
  logic [CW-1:0] emit_cnt_q;
  logic          emit_step, last_step;
  logic          out_valid_q;
  cell_ctl_t     ctl;

  assign emit_step = emitting_q && (!out_valid_q || out_ready_i);
  assign last_step = (emit_cnt_q == (k_act - CW'(1)));
  assign ctl.ins   = ev.ins;
  assign ctl.emit  = emit_step;
  assign ctl.clr   = emit_step && last_step;

  // cell row
  logic [DIST_WIDTH-1:0] c_dist  [K_MAX];
  logic [LABEL_W-1:0]    c_label [K_MAX];
  logic                  c_valid [K_MAX];
  logic                  sfx     [K_MAX+1];

  assign sfx[K_MAX] = 1'b1;

  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    logic [DIST_WIDTH-1:0] l_dist, r_dist;
    logic [LABEL_W-1:0]    l_label, r_label;
    logic                  l_valid, r_valid, l_sfx;

    if (i == 0) begin : g_first
      assign l_dist  = '1;
      assign l_label = '0;
      assign l_valid = 1'b0;
      assign l_sfx   = 1'b0;
    end else begin : g_mid
      assign l_dist  = c_dist[i-1];
      assign l_label = c_label[i-1];
      assign l_valid = c_valid[i-1];
      assign l_sfx   = sfx[i-1];
    end

    if (i == K_MAX - 1) begin : g_last
      assign r_dist  = '1;
      assign r_label = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_dist  = c_dist[i+1];
      assign r_label = c_label[i+1];
      assign r_valid = c_valid[i+1];
    end

    knntk_cell #(
      .DIST_WIDTH (DIST_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .in_range_i    (CW'(i) < k_act),
      .new_dist_i    (ins_dist),
      .new_label_i   (ins_label),
      .left_dist_i   (l_dist),
      .left_label_i  (l_label),
      .left_valid_i  (l_valid),
      .right_dist_i  (r_dist),
      .right_label_i (r_label),
      .right_valid_i (r_valid),
      .sfx_i         (sfx[i+1]),
      .sfx_left_i    (l_sfx),
      .sfx_o         (sfx[i]),
      .dist_o        (c_dist[i]),
      .label_o       (c_label[i]),
      .valid_o       (c_valid[i])
    );
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      emitting_q  <= 1'b0;
      emit_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire && last_ref_i) begin
        busy_q <= 1'b1;
      end else if (emit_step && last_step) begin
        busy_q <= 1'b0;
      end

      if (ev.done) begin
        emitting_q <= 1'b1;
        emit_cnt_q <= '0;
      end else if (emit_step) begin
        emitting_q <= !last_step;
        emit_cnt_q <= last_step ? '0 : emit_cnt_q + CW'(1);
      end

      if (emit_step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output register, loaded from the head cell
  always_ff @(posedge clk_i) begin
    if (emit_step) begin
      rank_o            <= emit_cnt_q[RANK_W-1:0];
      neighbour_dist_o  <= c_valid[0] ? c_dist[0] : '1;
      neighbour_label_o <= c_valid[0] ? c_label[0] : '0;
      slot_filled_o     <= c_valid[0];
      last_of_run_o     <= last_step;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/knntk_dist.sv =====
// squared euclidean distance pipeline: difference, square, saturating sum
`default_nettype none

module knntk_dist import knntk_pkg::*; #(
  parameter int unsigned ATTR_WIDTH = 16,
  parameter int unsigned DIST_WIDTH = 48
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  fire_i,
  input  wire logic [ATTR_WIDTH-1:0] query_attr_i,
  input  wire logic [ATTR_WIDTH-1:0] ref_attr_i,
  input  wire logic [LABEL_W-1:0]    ref_label_i,
  input  wire logic                  last_attr_i,
  input  wire logic                  last_ref_i,
  output dist_ev_t                   ev_o,
  output logic      [DIST_WIDTH-1:0] ins_dist_o,
  output logic      [LABEL_W-1:0]    ins_label_o
);

  localparam int unsigned SQ_W  = 2 * ATTR_WIDTH;
  localparam int unsigned SUM_W = ((SQ_W > DIST_WIDTH) ? SQ_W : DIST_WIDTH) + 1;
  localparam logic [SUM_W-1:0] DMAX = {{(SUM_W-DIST_WIDTH){1'b0}}, {DIST_WIDTH{1'b1}}};

  // stage 1: absolute difference
  logic [ATTR_WIDTH:0]   diff;
  logic [ATTR_WIDTH:0]   mag_full;
  logic [ATTR_WIDTH-1:0] mag_d, mag_q;
  logic [LABEL_W-1:0]    lbl1_q, lbl2_q;
  item_flags_t           f1_d, f1_q, f2_q;

  assign diff     = {query_attr_i[ATTR_WIDTH-1], query_attr_i}
                  - {ref_attr_i[ATTR_WIDTH-1], ref_attr_i};
  assign mag_full = diff[ATTR_WIDTH] ? (~diff + 1'b1) : diff;
  assign mag_d    = mag_full[ATTR_WIDTH-1:0];
  assign f1_d     = '{vld: fire_i, last_attr: last_attr_i, last_ref: last_ref_i};

  // stage 2: square
  logic [SQ_W-1:0] sq_d, sq_q;
  assign sq_d = SQ_W'(mag_q) * SQ_W'(mag_q);

  // stage 3: saturating accumulate
  logic [SUM_W-1:0]      sum;
  logic [DIST_WIDTH-1:0] sat;
  logic [DIST_WIDTH-1:0] acc_d, acc_q;
  dist_ev_t              ev_d, ev_q;

  assign sum = SUM_W'(acc_q) + SUM_W'(sq_q);
  assign sat = (sum > DMAX) ? {DIST_WIDTH{1'b1}} : sum[DIST_WIDTH-1:0];

  always_comb begin
    acc_d = acc_q;
    if (f2_q.vld) begin
      acc_d = (f2_q.last_attr || f2_q.last_ref) ? '0 : sat;
    end
    ev_d.ins  = f2_q.vld && f2_q.last_attr && (sat != '0);
    ev_d.done = f2_q.vld && f2_q.last_ref;
  end

  // control and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_q  <= '0;
      f2_q  <= '0;
      ev_q  <= '0;
      acc_q <= '0;
    end else begin
      f1_q  <= f1_d;
      f2_q  <= f1_q;
      ev_q  <= ev_d;
      acc_q <= acc_d;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    lbl1_q      <= ref_label_i;
    sq_q        <= sq_d;
    lbl2_q      <= lbl1_q;
    ins_dist_o  <= sat;
    ins_label_o <= lbl2_q;
  end

  assign ev_o = ev_q;

endmodule

`default_nettype wire

// ===== hw/rtl/knntk_cell.sv =====
// one slot of the sorted neighbor list with compare-and-shift logic
`default_nettype none

module knntk_cell import knntk_pkg::*; #(
  parameter int unsigned DIST_WIDTH = 48
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cell_ctl_t             ctl_i,
  input  wire logic                  in_range_i,
  input  wire logic [DIST_WIDTH-1:0] new_dist_i,
  input  wire logic [LABEL_W-1:0]    new_label_i,
  input  wire logic [DIST_WIDTH-1:0] left_dist_i,
  input  wire logic [LABEL_W-1:0]    left_label_i,
  input  wire logic                  left_valid_i,
  input  wire logic [DIST_WIDTH-1:0] right_dist_i,
  input  wire logic [LABEL_W-1:0]    right_label_i,
  input  wire logic                  right_valid_i,
  input  wire logic                  sfx_i,
  input  wire logic                  sfx_left_i,
  output logic                       sfx_o,
  output logic      [DIST_WIDTH-1:0] dist_o,
  output logic      [LABEL_W-1:0]    label_o,
  output logic                       valid_o
);

  logic [DIST_WIDTH-1:0] dist_d, dist_q;
  logic [LABEL_W-1:0]    label_d, label_q;
  logic                  valid_d, valid_q;
  logic                  goes_before;

  // new entry ranks ahead of this slot (empty slots always lose)
  assign goes_before = !valid_q || (new_dist_i < dist_q);
  // every in-range slot from here upward gives way
  assign sfx_o = in_range_i ? (goes_before && sfx_i) : 1'b1;

  // next slot contents
  always_comb begin
    dist_d  = dist_q;
    label_d = label_q;
    valid_d = valid_q;
    priority if (ctl_i.clr) begin
      valid_d = 1'b0;
    end else if (ctl_i.emit) begin
      dist_d  = right_dist_i;
      label_d = right_label_i;
      valid_d = right_valid_i;
    end else if (ctl_i.ins && in_range_i && sfx_o) begin
      if (sfx_left_i) begin
        dist_d  = left_dist_i;
        label_d = left_label_i;
        valid_d = left_valid_i;
      end else begin
        dist_d  = new_dist_i;
        label_d = new_label_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q  <= dist_d;
    label_q <= label_d;
  end

  assign dist_o  = dist_q;
  assign label_o = label_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/knntk_chk.sv =====
// port-level checker for the neighbor list and its bind to the top level
`default_nettype none

module knntk_chk #(
  parameter int unsigned DIST_WIDTH = 48
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic [3:0]            rank_o,
  input wire logic [DIST_WIDTH-1:0] neighbour_dist_o,
  input wire logic [7:0]            neighbour_label_o,
  input wire logic                  slot_filled_o,
  input wire logic                  last_of_run_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rank_o)
      && $stable(neighbour_dist_o) && $stable(neighbour_label_o)
      && $stable(slot_filled_o) && $stable(last_of_run_o))
    else $error("result changed while stalled");

  // no new query data is taken while a report is still in progress
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> !in_ready_o)
    else $error("input accepted during report");

  // empty slots report the cleared value
  a_empty_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !slot_filled_o |-> (&neighbour_dist_o) && (neighbour_label_o == 8'd0))
    else $error("empty slot carries data");

  // report ranks follow back to back
  a_rank_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=>
      out_valid_o && (rank_o == 4'($past(rank_o) + 4'd1)))
    else $error("report rank sequence broken");

endmodule

bind knn_top_k_distance_list knntk_chk #(.DIST_WIDTH(DIST_WIDTH)) u_chk (.*);

`default_nettype wire

// ===== verif/knn_top_k_distance_list_check.sv =====
// prediction and comparison of the k-nearest-neighbor report stream
module knn_top_k_distance_list_check import knntk_pkg::*; #(
  parameter int unsigned K_MAX      = 16,
  parameter int unsigned ATTR_WIDTH = 16,
  parameter int unsigned DIST_WIDTH = 48
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // apb configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  input  wire logic                  pready,
  // input channel
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_o,
  input  wire logic [ATTR_WIDTH-1:0] query_attr_i,
  input  wire logic [ATTR_WIDTH-1:0] ref_attr_i,
  input  wire logic [LABEL_W-1:0]    ref_label_i,
  input  wire logic                  last_attr_i,
  input  wire logic                  last_ref_i,
  // output channel
  input  wire logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire logic [RANK_W-1:0]     rank_o,
  input  wire logic [DIST_WIDTH-1:0] neighbour_dist_o,
  input  wire logic [LABEL_W-1:0]    neighbour_label_o,
  input  wire logic                  slot_filled_o,
  input  wire logic                  last_of_run_o,
  // status toward the stimulus side
  output int                         mismatches,
  output int                         reports_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [DIST_WIDTH-1:0] DIST_FULL = '1;
  localparam logic [APB_ADDR_W-1:0] K_ADDR = APB_ADDR_W'(4 * REG_K_IN_USE);
  localparam int unsigned PRINT_CAP = 50;

  typedef struct packed {
    logic [RANK_W-1:0]     rank;
    logic [DIST_WIDTH-1:0] nb_dist;
    logic [LABEL_W-1:0]    label;
    logic                  filled;
    logic                  last;
  } neighbour_report_t;

  neighbour_report_t     reports_owed[$];
  logic [KCFG_W-1:0]     k_setting;
  logic [DIST_WIDTH-1:0] dist_sum;
  logic [DIST_WIDTH-1:0] near_dist  [K_MAX];
  logic [LABEL_W-1:0]    near_label [K_MAX];
  logic                  near_used  [K_MAX];

  // drop every held neighbor
  task automatic clear_list();
    for (int i = 0; i < K_MAX; i++) begin
      near_dist[i]  = DIST_FULL;
      near_label[i] = '0;
      near_used[i]  = 1'b0;
    end
  endtask

  // fold one attribute pair into the running distance, update the list,
  // queue the report when the query closes
  task automatic absorb_pair(input logic signed [ATTR_WIDTH-1:0] qa,
                             input logic signed [ATTR_WIDTH-1:0] ra,
                             input logic [LABEL_W-1:0] lbl,
                             input logic la, input logic lr);
    logic signed [ATTR_WIDTH:0] diff;
    logic [DIST_WIDTH:0]        mag;
    logic [DIST_WIDTH:0]        total;
    int                         k;
    int                         pos;
    neighbour_report_t          rpt;
    diff = qa - ra;
    mag = diff[ATTR_WIDTH] ? -diff : diff;
    mag = mag & {{(DIST_WIDTH - ATTR_WIDTH){1'b0}}, {(ATTR_WIDTH + 1){1'b1}}};
    total = {1'b0, dist_sum} + mag * mag;
    dist_sum = total[DIST_WIDTH] ? DIST_FULL : total[DIST_WIDTH-1:0];

    // register value zero acts as one, above the list size as the list size
    k = k_setting;
    if (k == 0) k = 1;
    if (k > K_MAX) k = K_MAX;

    // sorted insertion, equal distances land behind the ones already held
    if (la) begin
      if (dist_sum != '0) begin
        pos = k - 1;
        while (pos >= 0 && (!near_used[pos] || dist_sum < near_dist[pos])) pos--;
        pos++;
        if (pos < k) begin
          for (int c = k - 2; c >= pos; c--) begin
            near_dist[c + 1]  = near_dist[c];
            near_label[c + 1] = near_label[c];
            near_used[c + 1]  = near_used[c];
          end
          near_dist[pos]  = dist_sum;
          near_label[pos] = lbl;
          near_used[pos]  = 1'b1;
        end
      end
      dist_sum = '0;
    end

    // query closed: report k slots in rank order, then start over
    if (lr) begin
      for (int i = 0; i < k; i++) begin
        rpt.rank    = RANK_W'(i);
        rpt.nb_dist = near_used[i] ? near_dist[i] : DIST_FULL;
        rpt.label   = near_used[i] ? near_label[i] : '0;
        rpt.filled  = near_used[i];
        rpt.last    = (i == k - 1);
        reports_owed.push_back(rpt);
      end
      clear_list();
      dist_sum = '0;
    end
  endtask

  task automatic flag_field(input string what, input logic [63:0] want,
                            input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= PRINT_CAP) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    neighbour_report_t want;
    if (!rst_ni) begin
      k_setting = K_RESET;
      dist_sum  = '0;
      clear_list();
      reports_owed.delete();
      reports_due = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == K_ADDR) begin
        k_setting = pwdata[KCFG_W-1:0];
      end
      // output transaction against the oldest expected report
      if (out_valid_o && out_ready_i) begin
        if (reports_owed.size() == 0) begin
          mismatches++;
          if (mismatches <= PRINT_CAP) begin
            $display("%0t ns: report with none expected, expected nothing, actual rank %0d dist %0h label %0h",
                     $time, rank_o, neighbour_dist_o, neighbour_label_o);
          end
        end else begin
          want = reports_owed.pop_front();
          flag_field("rank", 64'(want.rank), 64'(rank_o));
          flag_field("neighbour_dist", 64'(want.nb_dist), 64'(neighbour_dist_o));
          flag_field("neighbour_label", 64'(want.label), 64'(neighbour_label_o));
          flag_field("slot_filled", 64'(want.filled), 64'(slot_filled_o));
          flag_field("last_of_run", 64'(want.last), 64'(last_of_run_o));
        end
      end
      // input transaction
      if (in_valid_i && in_ready_o) begin
        absorb_pair(query_attr_i, ref_attr_i, ref_label_i, last_attr_i, last_ref_i);
      end
      reports_due = reports_owed.size();
    end
  end

endmodule

// ===== verif/knn_top_k_distance_list_tb.sv =====
// stimulus, clock, reset and verdict for the k-nearest-neighbor distance list
module knn_top_k_distance_list_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import knntk_pkg::*;

  localparam int unsigned K_MAX       = 16;
  localparam int unsigned ATTR_WIDTH  = 16;
  localparam int unsigned DIST_WIDTH  = 48;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned PIPE_SETTLE = 12;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam logic [APB_ADDR_W-1:0] K_ADDR = APB_ADDR_W'(4 * REG_K_IN_USE);

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [ATTR_WIDTH-1:0] query_attr_i = '0;
  logic [ATTR_WIDTH-1:0] ref_attr_i = '0;
  logic [LABEL_W-1:0]    ref_label_i = '0;
  logic                  last_attr_i = 1'b0;
  logic                  last_ref_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [RANK_W-1:0]     rank_o;
  logic [DIST_WIDTH-1:0] neighbour_dist_o;
  logic [LABEL_W-1:0]    neighbour_label_o;
  logic                  slot_filled_o;
  logic                  last_of_run_o;
  int                    mismatches;
  int                    reports_due;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_req = 0;
  int          hold_left = 0;
  int          sent_items = 0;
  int unsigned cycle_count = 0;

  knn_top_k_distance_list #(
    .K_MAX(K_MAX), .ATTR_WIDTH(ATTR_WIDTH), .DIST_WIDTH(DIST_WIDTH)
  ) dut (.*);

  knn_top_k_distance_list_check #(
    .K_MAX(K_MAX), .ATTR_WIDTH(ATTR_WIDTH), .DIST_WIDTH(DIST_WIDTH)
  ) check_u (.*);

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("knn_top_k_distance_list verification failed");
      $finish;
    end
  end

  // report side: random stalls, plus a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(input logic [ATTR_WIDTH-1:0] qa, input logic [ATTR_WIDTH-1:0] ra,
                           input logic [LABEL_W-1:0] lbl, input logic la, input logic lr);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    query_attr_i <= qa;
    ref_attr_i   <= ra;
    ref_label_i  <= lbl;
    last_attr_i  <= la;
    last_ref_i   <= lr;
    do @(posedge clk_i); while (!in_ready_o);
    sent_items++;
  endtask

  // stop offering, let every report arrive and the pipeline empty out
  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (reports_due != 0) @(negedge clk_i);
    repeat (PIPE_SETTLE) @(negedge clk_i);
  endtask

  // apb write of k_in_use, junk in the unused upper bits
  task automatic write_k(input logic [KCFG_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= K_ADDR;
    pwdata  <= {(APB_DATA_W - KCFG_W)'($urandom()), val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one reference element: close pairs, equal pairs, extremes or anything
  task automatic send_ref(input int n_attr, input logic closes_query);
    logic [ATTR_WIDTH-1:0] qa;
    logic [ATTR_WIDTH-1:0] ra;
    logic [LABEL_W-1:0]    lbl;
    int                    style;
    lbl = LABEL_W'($urandom());
    style = $urandom_range(0, 9);
    for (int a = 0; a < n_attr; a++) begin
      qa = ATTR_WIDTH'($urandom());
      case (style)
        0, 1, 2, 3: ra = qa + ATTR_WIDTH'($urandom_range(0, 6)) - ATTR_WIDTH'(3);
        4: ra = qa;
        5: begin
          qa = $urandom_range(1) ? 16'h7FFF : 16'h8000;
          ra = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        end
        default: ra = ATTR_WIDTH'($urandom());
      endcase
      send_item(qa, ra, lbl, a == n_attr - 1, closes_query && a == n_attr - 1);
    end
  endtask

  // one query: mostly well formed, sometimes closed in mid reference
  task automatic send_query();
    int n_refs;
    int roll;
    n_refs = ($urandom_range(9) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 8);
    roll = $urandom_range(99);
    for (int r = 0; r < n_refs; r++) begin
      send_ref($urandom_range(1, 4), r == n_refs - 1 && roll >= 15);
    end
    if (roll < 15) begin
      for (int a = $urandom_range(0, 2); a > 0; a--) begin
        send_item(ATTR_WIDTH'($urandom()), ATTR_WIDTH'($urandom()), LABEL_W'($urandom()),
                  1'b0, 1'b0);
      end
      send_item(ATTR_WIDTH'($urandom()), ATTR_WIDTH'($urandom()), LABEL_W'($urandom()),
                1'b0, 1'b1);
    end
  endtask

  initial begin
    int                start;
    logic [KCFG_W-1:0] phase_k;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset k of five: extremes, zero distance, ties, a short last reference
    send_item(16'h7FFF, 16'h8000, 8'hAA, 1'b1, 1'b0);
    send_item(16'd100, 16'd100, 8'h02, 1'b1, 1'b0);
    send_item(16'd1, 16'd0, 8'h03, 1'b0, 1'b0);
    send_item(16'd0, 16'd1, 8'h03, 1'b1, 1'b0);
    send_item(16'd5, 16'd4, 8'h04, 1'b0, 1'b0);
    send_item(16'hFFFD, 16'hFFFE, 8'h04, 1'b1, 1'b0);
    send_item(16'h8000, 16'h7FFF, 8'h55, 1'b1, 1'b0);
    send_item(16'd7, 16'd7, 8'h06, 1'b0, 1'b0);
    send_item(16'd0, 16'd1, 8'h06, 1'b1, 1'b0);
    send_item(16'd3, 16'd0, 8'h09, 1'b0, 1'b1);
    wait_quiet();

    // k of zero behaves as one
    write_k(5'd0);
    send_item(16'd10, 16'd0, 8'h01, 1'b1, 1'b0);
    send_item(16'd0, 16'd3, 8'h02, 1'b1, 1'b0);
    send_item(16'd0, 16'd20, 8'h03, 1'b1, 1'b0);
    send_item(16'd0, 16'd0, 8'h04, 1'b1, 1'b1);
    wait_quiet();

    // k above the list size, mostly empty slots reported
    write_k(5'd31);
    send_item(16'd2, 16'd0, 8'hFF, 1'b1, 1'b1);
    wait_quiet();

    // k shrinks and then grows within one query
    write_k(5'd3);
    send_item(16'd3, 16'd0, 8'h01, 1'b1, 1'b0);
    send_item(16'd2, 16'd0, 8'h02, 1'b1, 1'b0);
    send_item(16'd4, 16'd0, 8'h03, 1'b1, 1'b0);
    send_item(16'd1, 16'd0, 8'h04, 1'b1, 1'b0);
    wait_quiet();
    write_k(5'd2);
    send_item(16'd1, 16'd0, 8'h05, 1'b0, 1'b0);
    send_item(16'd1, 16'd0, 8'h05, 1'b1, 1'b0);
    wait_quiet();
    write_k(5'd4);
    send_item(16'd1, 16'd0, 8'h06, 1'b0, 1'b0);
    send_item(16'd1, 16'd0, 8'h06, 1'b0, 1'b0);
    send_item(16'd1, 16'd0, 8'h06, 1'b1, 1'b0);
    send_item(16'd0, 16'd0, 8'h07, 1'b1, 1'b1);

    // random queries under four idling patterns
    for (int ph = 0; ph < 4; ph++) begin
      wait_quiet();
      case (ph)
        0: phase_k = 5'd16;
        1: phase_k = 5'd1;
        2: phase_k = KCFG_W'($urandom_range(0, 31));
        default: phase_k = 5'd12;
      endcase
      write_k(phase_k);
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_req = 400;
        end
        1: begin
          send_idle_pct = 56;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 56;
        end
        default: begin
          send_idle_pct = 38;
          recv_stall_pct = 38;
        end
      endcase
      start = sent_items;
      while (sent_items - start < PHASE_ITEMS) send_query();
    end

    // drain and verdict
    wait_quiet();
    if (mismatches == 0) begin
      $display("knn_top_k_distance_list verification clean");
    end else begin
      $display("knn_top_k_distance_list verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/knntk_pkg.sv
hw/rtl/knntk_dist.sv
hw/rtl/knntk_cell.sv
hw/rtl/knn_top_k_distance_list.sv
hw/rtl/knntk_chk.sv
verif/knn_top_k_distance_list_check.sv
verif/knn_top_k_distance_list_tb.sv
